// ===== src/rdir_pkg.sv =====
// ============================================================================
// rdir_pkg
// Shared widths, types, constants and helpers of the refraction block.
// ============================================================================
`default_nettype none

package rdir_pkg;

    // Fixed-point formats of the component fields
    localparam int COMPONENT_WIDTH = 16;
    localparam int FRACTION_BITS   = 14;
    localparam int ONE_FIX         = 1 << FRACTION_BITS;

    // Index of refraction is Q2.12; values below one are raised to one
    localparam int IOR_FRACTION = 12;
    localparam int IOR_ONE      = 1 << IOR_FRACTION;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;
    localparam logic [CFG_IDX_W-1:0] REG_KT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IOR = 1'd1;

    // Pipeline depths
    localparam int SQRT_STAGES = 15;
    localparam int DIV_QBITS   = 16;
    localparam int DIV_STAGES  = DIV_QBITS + 1;

    typedef logic signed [COMPONENT_WIDTH-1:0] comp_t;
    typedef comp_t [2:0]                        vec_t;
    typedef logic [14:0]                        unit_t;   // 0 .. 1.0
    typedef logic [14:0]                        kt_t;
    typedef logic [13:0]                        ior_t;
    typedef logic [17:0]                        rval_t;   // 1/eta or eta, Q16
    typedef logic [19:0]                        r2_t;     // r squared, Q16
    typedef logic [34:0]                        amul_t;   // kt * r2
    typedef logic [16:0]                        crs_t;    // c * r, Q14
    typedef logic signed [17:0]                 vr_t;     // v * r, Q14
    typedef vr_t [2:0]                          vrvec_t;

    // Per-configuration coefficients, both orientations
    typedef struct packed {
        rval_t r_nf;
        r2_t   r2_nf;
        amul_t a_nf;
        rval_t r_f;
        r2_t   r2_f;
        amul_t a_f;
    } coef_t;

    // Operands carried alongside the square root
    typedef struct packed {
        logic   tir;
        crs_t   crs;
        vrvec_t vr;
        vec_t   m;
        vec_t   n;
        amul_t  a;
    } side_t;

    typedef struct packed {
        unit_t temp;
        side_t side;
    } front_t;

    typedef struct packed {
        unit_t c2;
        side_t side;
    } root_t;

    typedef struct packed {
        logic        tir;
        vec_t        w;
        logic [15:0] b;
        amul_t       a;
    } quot_in_t;

    typedef struct packed {
        logic tir;
        vec_t w;
    } quot_side_t;

    typedef struct packed {
        vec_t        w;
        logic [15:0] scale;
        logic        tir;
        logic        sat;
    } result_t;

    // Saturate to [-1.0, +1.0]
    function automatic comp_t sat_unit(input logic signed [22:0] x);
        comp_t y;
        if (x > 23'(ONE_FIX))
            y = comp_t'(ONE_FIX);
        else if (x < -23'(ONE_FIX))
            y = -comp_t'(ONE_FIX);
        else
            y = x[COMPONENT_WIDTH-1:0];
        return y;
    endfunction

endpackage

`default_nettype wire

// ===== src/rdir_coef.sv =====
// ============================================================================
// rdir_coef
// Configuration registers and the coefficient builder: reciprocal of the
// index by restoring division, then squares and kt products on one multiplier.
// ============================================================================
`default_nettype none

module rdir_coef
    import rdir_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output coef_t                 coef,
    output logic                  busy
);

    typedef enum logic [3:0] {
        ST_LOAD = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_IDLE = 4'b1000
    } coef_state_t;

    coef_state_t state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    kt_t         kt_reg;
    ior_t        ior_reg;
    logic [28:0] drem_reg, drem_next;
    logic [16:0] dq_reg, dq_next;
    r2_t         r2nf_reg, r2f_reg;
    amul_t       anf_reg, af_reg;

    ior_t        iorc;
    rval_t       rf;
    logic [29:0] dtrial;
    logic        dtake;
    logic [19:0] mul_a, mul_b;
    logic [39:0] prod;

    // Clamped index and the exact flipped reciprocal
    assign iorc = (ior_reg < ior_t'(IOR_ONE)) ? ior_t'(IOR_ONE) : ior_reg;
    assign rf   = {iorc, 4'b0000};

    // One quotient bit per cycle
    assign dtrial = 30'(iorc) << cnt_reg;
    assign dtake  = 30'(drem_reg) >= dtrial;

    // Shared multiplier operands
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:
            begin
                mul_a = 20'(dq_reg);
                mul_b = 20'(dq_reg);
            end
            2'd1:
            begin
                mul_a = 20'(rf);
                mul_b = 20'(rf);
            end
            2'd2:
            begin
                mul_a = 20'(kt_reg);
                mul_b = r2nf_reg;
            end
            default:
            begin
                mul_a = 20'(kt_reg);
                mul_b = r2f_reg;
            end
        endcase
    end
    assign prod = mul_a * mul_b;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        drem_next  = drem_reg;
        dq_next    = dq_reg;
        case (state_reg)
            ST_LOAD:
            begin
                drem_next  = 29'd1 << 28;
                dq_next    = '0;
                cnt_next   = 5'd16;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (dtake)
                    drem_next = drem_reg - dtrial[28:0];
                dq_next = {dq_reg[15:0], dtake};
                if (cnt_reg == 5'd0)
                    state_next = ST_MUL;
                else
                    cnt_next = cnt_reg - 5'd1;
            end
            ST_MUL:
            begin
                if (cnt_reg == 5'd3)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_IDLE:
            begin
                if (cfg_valid)
                    state_next = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            kt_reg    <= kt_t'(2458);
            ior_reg   <= ior_t'(6144);
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_KT:  kt_reg  <= cfg_data[14:0];
                    REG_IOR: ior_reg <= cfg_data[13:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        drem_reg <= drem_next;
        dq_reg   <= dq_next;
        if (state_reg == ST_MUL)
        begin
            case (cnt_reg[1:0])
                2'd0:    r2nf_reg <= prod[35:16];
                2'd1:    r2f_reg  <= prod[35:16];
                2'd2:    anf_reg  <= prod[34:0];
                default: af_reg   <= prod[34:0];
            endcase
        end
    end

    assign cfg_ready  = (state_reg == ST_IDLE);
    assign busy       = (state_reg != ST_IDLE);
    assign coef.r_nf  = rval_t'(dq_reg);
    assign coef.r2_nf = r2nf_reg;
    assign coef.a_nf  = anf_reg;
    assign coef.r_f   = rf;
    assign coef.r2_f  = r2f_reg;
    assign coef.a_f   = af_reg;

endmodule

`default_nettype wire

// ===== src/rdir_geom.sv =====
// ============================================================================
// rdir_geom
// Front stages: input clamp, cosine of incidence, orientation flip and the
// radicand 1 - (1 - c^2) r^2 with the v*r terms.
// ============================================================================
`default_nettype none

module rdir_geom
    import rdir_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  vec_t   n_in,
    input  vec_t   v_in,
    input  coef_t  coef,
    output logic   out_valid,
    input  logic   out_ready,
    output front_t out_data
);

    localparam int NS = 5;

    logic v_reg [NS];
    logic en    [NS];

    // stage 1
    vec_t n1_reg, v1_reg;
    // stage 2
    logic signed [29:0] p2_reg [3];
    vec_t n2_reg, v2_reg;
    // stage 3
    unit_t c3_reg;
    rval_t r3_reg;
    r2_t   r23_reg;
    amul_t a3_reg;
    vec_t  m3_reg, n3_reg, v3_reg;
    // stage 4
    unit_t sin4_reg;
    crs_t  crs4_reg;
    rval_t r4_reg;
    r2_t   r24_reg;
    amul_t a4_reg;
    vec_t  m4_reg, n4_reg, v4_reg;
    // stage 5
    front_t out_reg;

    logic signed [31:0] dot3;
    logic signed [17:0] c18;
    logic signed [18:0] cmag;
    logic               flip3;
    unit_t              c3_next;
    vec_t               m3_next;
    logic [29:0]        cc4, diff4;
    logic [32:0]        cr4;
    logic [34:0]        t5;
    logic signed [19:0] temp5;
    logic signed [34:0] vrp5 [3];

    // Ready ripples back through empty stages
    assign en[NS-1] = !v_reg[NS-1] || out_ready;
    for (genvar i = 0; i < NS - 1; i++)
    begin : g_en
        assign en[i] = !v_reg[i] || en[i+1];
    end
    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
                v_reg[i] <= 1'b0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++)
                if (en[i])
                    v_reg[i] <= v_reg[i-1];
        end
    end

    // Cosine, flip and clamp
    always_comb
    begin
        dot3  = 32'(p2_reg[0]) + 32'(p2_reg[1]) + 32'(p2_reg[2]);
        flip3 = dot3[31];
        c18   = dot3[31:14];
        cmag  = flip3 ? -19'(c18) : 19'(c18);
        c3_next = (cmag > 19'(ONE_FIX)) ? unit_t'(ONE_FIX) : cmag[14:0];
        for (int i = 0; i < 3; i++)
            m3_next[i] = flip3 ? -n2_reg[i] : n2_reg[i];
    end

    // sin^2 and c*r
    assign cc4   = 30'(c3_reg) * 30'(c3_reg);
    assign diff4 = (30'd1 << (2 * FRACTION_BITS)) - cc4;
    assign cr4   = 33'(c3_reg) * 33'(r3_reg);

    // Radicand and v*r
    always_comb
    begin
        t5    = 35'(sin4_reg) * 35'(r24_reg);
        temp5 = 20'(ONE_FIX) - $signed({1'b0, t5[34:16]});
        for (int i = 0; i < 3; i++)
            vrp5[i] = 35'($signed(v4_reg[i])) * 35'($signed({1'b0, r4_reg}));
    end

    always_ff @(posedge clk)
    begin
        if (en[0] && in_valid)
        begin
            for (int i = 0; i < 3; i++)
            begin
                n1_reg[i] <= sat_unit(23'($signed(n_in[i])));
                v1_reg[i] <= sat_unit(23'($signed(v_in[i])));
            end
        end
        if (en[1] && v_reg[0])
        begin
            for (int i = 0; i < 3; i++)
                p2_reg[i] <= 30'($signed(n1_reg[i]) * $signed(v1_reg[i]));
            n2_reg <= n1_reg;
            v2_reg <= v1_reg;
        end
        if (en[2] && v_reg[1])
        begin
            c3_reg  <= c3_next;
            r3_reg  <= flip3 ? coef.r_f  : coef.r_nf;
            r23_reg <= flip3 ? coef.r2_f : coef.r2_nf;
            a3_reg  <= flip3 ? coef.a_f  : coef.a_nf;
            m3_reg  <= m3_next;
            n3_reg  <= n2_reg;
            v3_reg  <= v2_reg;
        end
        if (en[3] && v_reg[2])
        begin
            sin4_reg <= diff4[28:14];
            crs4_reg <= cr4[32:16];
            r4_reg   <= r3_reg;
            r24_reg  <= r23_reg;
            a4_reg   <= a3_reg;
            m4_reg   <= m3_reg;
            n4_reg   <= n3_reg;
            v4_reg   <= v3_reg;
        end
        if (en[4] && v_reg[3])
        begin
            out_reg.temp     <= temp5[14:0];
            out_reg.side.tir <= temp5[19];
            out_reg.side.crs <= crs4_reg;
            for (int i = 0; i < 3; i++)
                out_reg.side.vr[i] <= vrp5[i][33:16];
            out_reg.side.m   <= m4_reg;
            out_reg.side.n   <= n4_reg;
            out_reg.side.a   <= a4_reg;
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// ===== src/rdir_sqrt.sv =====
// ============================================================================
// rdir_sqrt
// Pipelined floor square root of the radicand, one root bit per stage.
// ============================================================================
`default_nettype none

module rdir_sqrt
    import rdir_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  front_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output root_t  out_data
);

    localparam int NS = SQRT_STAGES;

    logic        v_reg   [NS];
    logic        en      [NS];
    unit_t       res_reg [NS];
    logic [29:0] rem_reg [NS];
    side_t       side_reg[NS];

    assign en[NS-1] = !v_reg[NS-1] || out_ready;
    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
                v_reg[i] <= 1'b0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++)
                if (en[i])
                    v_reg[i] <= v_reg[i-1];
        end
    end

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        localparam int J = NS - 1 - s;

        unit_t       res_in;
        logic [29:0] rem_in;
        side_t       side_in;
        logic        v_in;
        logic [30:0] trial;
        logic        take;

        if (s == 0)
        begin : g_first
            assign res_in  = '0;
            assign rem_in  = 30'({in_data.temp, {FRACTION_BITS{1'b0}}});
            assign side_in = in_data.side;
            assign v_in    = in_valid;
        end
        else
        begin : g_next
            assign res_in  = res_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign side_in = side_reg[s-1];
            assign v_in    = v_reg[s-1];
        end

        if (s < NS - 1)
        begin : g_en
            assign en[s] = !v_reg[s] || en[s+1];
        end

        // (res + 2^J)^2 - res^2
        assign trial = (31'(res_in) << (J + 1)) + (31'd1 << (2 * J));
        assign take  = 31'(rem_in) >= trial;

        always_ff @(posedge clk)
        begin
            if (en[s] && v_in)
            begin
                res_reg[s]  <= take ? (res_in | unit_t'(1 << J)) : res_in;
                rem_reg[s]  <= take ? (rem_in - trial[29:0]) : rem_in;
                side_reg[s] <= side_in;
            end
        end
    end

    assign out_valid     = v_reg[NS-1];
    assign out_data.c2   = res_reg[NS-1];
    assign out_data.side = side_reg[NS-1];

endmodule

`default_nettype wire

// ===== src/rdir_dirc.sv =====
// ============================================================================
// rdir_dirc
// Refracted direction wt = -v r - (c2 - c r) m, saturated, and the divisor
// |n . wt| for the radiance scale.
// ============================================================================
`default_nettype none

module rdir_dirc
    import rdir_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  root_t    in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output quot_in_t out_data
);

    localparam int NS = 5;

    logic v_reg [NS];
    logic en    [NS];

    // stage 1
    logic signed [17:0] k1_reg;
    logic               tir1_reg;
    vrvec_t             vr1_reg;
    vec_t               m1_reg, n1_reg;
    amul_t              a1_reg;
    // stage 2
    logic signed [19:0] km2_reg [3];
    logic               tir2_reg;
    vrvec_t             vr2_reg;
    vec_t               n2_reg;
    amul_t              a2_reg;
    // stage 3
    vec_t               w3_reg, n3_reg;
    logic               tir3_reg;
    amul_t              a3_reg;
    // stage 4
    logic signed [29:0] q4_reg [3];
    vec_t               w4_reg;
    logic               tir4_reg;
    amul_t              a4_reg;
    // stage 5
    quot_in_t           out_reg;

    logic signed [33:0] kmp  [3];
    logic signed [21:0] tsum [3];
    logic signed [31:0] dot5;
    logic [31:0]        mag5;

    assign en[NS-1] = !v_reg[NS-1] || out_ready;
    for (genvar i = 0; i < NS - 1; i++)
    begin : g_en
        assign en[i] = !v_reg[i] || en[i+1];
    end
    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
                v_reg[i] <= 1'b0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++)
                if (en[i])
                    v_reg[i] <= v_reg[i-1];
        end
    end

    // Products, direction sums and the divisor
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            kmp[i]  = 34'(k1_reg) * 34'($signed(m1_reg[i]));
            tsum[i] = -22'($signed(vr2_reg[i])) - 22'(km2_reg[i]);
        end
        dot5 = 32'(q4_reg[0]) + 32'(q4_reg[1]) + 32'(q4_reg[2]);
        mag5 = dot5[31] ? 32'(-dot5) : 32'(dot5);
    end

    always_ff @(posedge clk)
    begin
        if (en[0] && in_valid)
        begin
            k1_reg   <= $signed({3'b000, in_data.c2}) - $signed({1'b0, in_data.side.crs});
            tir1_reg <= in_data.side.tir;
            vr1_reg  <= in_data.side.vr;
            m1_reg   <= in_data.side.m;
            n1_reg   <= in_data.side.n;
            a1_reg   <= in_data.side.a;
        end
        if (en[1] && v_reg[0])
        begin
            for (int i = 0; i < 3; i++)
                km2_reg[i] <= kmp[i][33:14];
            tir2_reg <= tir1_reg;
            vr2_reg  <= vr1_reg;
            n2_reg   <= n1_reg;
            a2_reg   <= a1_reg;
        end
        if (en[2] && v_reg[1])
        begin
            // zero direction on internal reflection
            for (int i = 0; i < 3; i++)
                w3_reg[i] <= tir2_reg ? '0 : sat_unit(23'(tsum[i]));
            n3_reg   <= n2_reg;
            tir3_reg <= tir2_reg;
            a3_reg   <= a2_reg;
        end
        if (en[3] && v_reg[2])
        begin
            for (int i = 0; i < 3; i++)
                q4_reg[i] <= 30'($signed(n3_reg[i]) * $signed(w3_reg[i]));
            w4_reg   <= w3_reg;
            tir4_reg <= tir3_reg;
            a4_reg   <= a3_reg;
        end
        if (en[4] && v_reg[3])
        begin
            out_reg.tir <= tir4_reg;
            out_reg.w   <= w4_reg;
            out_reg.b   <= mag5[29:14];
            out_reg.a   <= a4_reg;
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_data  = out_reg;

endmodule

`default_nettype wire

// ===== src/rdir_div.sv =====
// ============================================================================
// rdir_div
// Radiance scale a / (b * 2^8): overflow check, then one quotient bit per
// stage by restoring division. Saturates on overflow or a zero divisor.
// ============================================================================
`default_nettype none

module rdir_div
    import rdir_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  quot_in_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output result_t  out_data
);

    localparam int NS = DIV_STAGES;

    logic        v_reg    [NS];
    logic        en       [NS];
    amul_t       rem_reg  [NS];
    logic [23:0] bsh_reg  [NS];
    logic [15:0] q_reg    [NS];
    logic        ov_reg   [NS];
    quot_side_t  side_reg [NS];

    assign en[NS-1] = !v_reg[NS-1] || out_ready;
    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
                v_reg[i] <= 1'b0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++)
                if (en[i])
                    v_reg[i] <= v_reg[i-1];
        end
    end

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        if (s < NS - 1)
        begin : g_en
            assign en[s] = !v_reg[s] || en[s+1];
        end

        if (s == 0)
        begin : g_check
            logic [23:0] bsh;
            assign bsh = {in_data.b, 8'h00};

            // quotient above 16 bits, or zero divisor
            always_ff @(posedge clk)
            begin
                if (en[0] && in_valid)
                begin
                    rem_reg[0]      <= in_data.a;
                    bsh_reg[0]      <= bsh;
                    q_reg[0]        <= '0;
                    ov_reg[0]       <= 24'(in_data.a[34:16]) >= bsh;
                    side_reg[0].tir <= in_data.tir;
                    side_reg[0].w   <= in_data.w;
                end
            end
        end
        else
        begin : g_bit
            localparam int J = NS - 1 - s;

            logic [39:0] trial;
            logic        take;

            assign trial = 40'(bsh_reg[s-1]) << J;
            assign take  = !ov_reg[s-1] && (40'(rem_reg[s-1]) >= trial);

            always_ff @(posedge clk)
            begin
                if (en[s] && v_reg[s-1])
                begin
                    rem_reg[s]  <= take ? (rem_reg[s-1] - trial[34:0]) : rem_reg[s-1];
                    bsh_reg[s]  <= bsh_reg[s-1];
                    q_reg[s]    <= {q_reg[s-1][14:0], take};
                    ov_reg[s]   <= ov_reg[s-1];
                    side_reg[s] <= side_reg[s-1];
                end
            end
        end
    end

    // Result select: zero on internal reflection, full scale on overflow
    always_comb
    begin
        out_data.w   = side_reg[NS-1].w;
        out_data.tir = side_reg[NS-1].tir;
        out_data.sat = !side_reg[NS-1].tir && ov_reg[NS-1];
        if (side_reg[NS-1].tir)
            out_data.scale = '0;
        else if (ov_reg[NS-1])
            out_data.scale = '1;
        else
            out_data.scale = q_reg[NS-1];
    end

    assign out_valid = v_reg[NS-1];

endmodule

`default_nettype wire

// ===== src/refraction_direction_top.sv =====
// ============================================================================
// refraction_direction_top
// Snell refraction of a view direction through a surface, fixed point.
// ============================================================================
// The block takes one normal/view pair per cycle while in_stall is low and
// returns one result per pair, in order, through 5 front stages (clamp,
// cosine, flip, radicand), 15 square-root stages, 5 direction stages and 17
// divider stages for the radiance scale. Each stage holds its item until the
// next one frees, so gaps close up while the output is stalled. After reset
// and after every configuration write, in_stall stays high while the
// coefficient unit rebuilds 1/eta on its restoring divider and the squared
// and kt-scaled terms on its shared multiplier; cfg_ready is low for the
// same time.
// ============================================================================
`default_nettype none

module refraction_direction_top
    import rdir_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  comp_t                 normal_x,
    input  comp_t                 normal_y,
    input  comp_t                 normal_z,
    input  comp_t                 view_x,
    input  comp_t                 view_y,
    input  comp_t                 view_z,

    output logic                  out_valid,
    input  logic                  out_stall,
    output comp_t                 dir_x,
    output comp_t                 dir_y,
    output comp_t                 dir_z,
    output logic [15:0]           radiance_scale,
    output logic                  internal_reflection,
    output logic                  scale_saturated
);

    coef_t    coef;
    logic     busy;
    logic     geom_ready, geom_valid;
    front_t   geom_data;
    logic     sqrt_ready, sqrt_valid;
    root_t    sqrt_data;
    logic     dirc_ready, dirc_valid;
    quot_in_t dirc_data;
    logic     div_ready;
    result_t  result;
    vec_t     n_in, v_in;

    assign n_in = {normal_z, normal_y, normal_x};
    assign v_in = {view_z, view_y, view_x};

    rdir_coef u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef),
        .busy      (busy)
    );

    // No transfer while coefficients are rebuilt
    assign in_stall = busy || !geom_ready;

    rdir_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid && !busy),
        .in_ready  (geom_ready),
        .n_in      (n_in),
        .v_in      (v_in),
        .coef      (coef),
        .out_valid (geom_valid),
        .out_ready (sqrt_ready),
        .out_data  (geom_data)
    );

    rdir_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (geom_valid),
        .in_ready  (sqrt_ready),
        .in_data   (geom_data),
        .out_valid (sqrt_valid),
        .out_ready (dirc_ready),
        .out_data  (sqrt_data)
    );

    rdir_dirc u_dirc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sqrt_valid),
        .in_ready  (dirc_ready),
        .in_data   (sqrt_data),
        .out_valid (dirc_valid),
        .out_ready (div_ready),
        .out_data  (dirc_data)
    );

    rdir_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dirc_valid),
        .in_ready  (div_ready),
        .in_data   (dirc_data),
        .out_valid (out_valid),
        .out_ready (!out_stall),
        .out_data  (result)
    );

    assign dir_x               = result.w[0];
    assign dir_y               = result.w[1];
    assign dir_z               = result.w[2];
    assign radiance_scale      = result.scale;
    assign internal_reflection = result.tir;
    assign scale_saturated     = result.sat;

endmodule

`default_nettype wire

// ===== src/rdir_checker.sv =====
// ============================================================================
// rdir_checker
// Port-level checks of the refraction block, bound to the top level.
// ============================================================================
`default_nettype none

module rdir_checker
    import rdir_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input comp_t                 dir_x,
    input comp_t                 dir_y,
    input comp_t                 dir_z,
    input logic [15:0]           radiance_scale,
    input logic                  internal_reflection,
    input logic                  scale_saturated
);

    // Internal reflection gives a zero result
    a_tir_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && internal_reflection |->
            dir_x == 0 && dir_y == 0 && dir_z == 0 &&
            radiance_scale == 0 && !scale_saturated)
        else $error("internal reflection with nonzero result");

    // A saturated scale sits at full scale
    a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scale_saturated |-> radiance_scale == 16'hFFFF)
        else $error("saturation flag without full-scale value");

    // Direction components stay within one
    a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            dir_x <= 16'sd16384 && dir_x >= -16'sd16384 &&
            dir_y <= 16'sd16384 && dir_y >= -16'sd16384 &&
            dir_z <= 16'sd16384 && dir_z >= -16'sd16384)
        else $error("direction component out of range");

    // A configuration write blocks input while coefficients rebuild
    a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> in_stall && !cfg_ready)
        else $error("input open right after configuration write");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            out_valid && $stable(radiance_scale) && $stable(dir_x) &&
            $stable(dir_y) && $stable(dir_z))
        else $error("stalled result changed");

endmodule

bind refraction_direction_top rdir_checker u_rdir_checker (.*);

`default_nettype wire
